// ===== rtl/core/xmr_pkg.sv =====
package xmr_pkg;

    localparam int PAYLOAD_BYTES = 128;
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_CRC_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd1;

    localparam logic [3:0] RETRY_LIMIT_RST = 4'd10;

    localparam logic [7:0] BYTE_C   = 8'h43;
    localparam logic [7:0] BYTE_NAK = 8'h15;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_EOT = 8'h04;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_FAILED  = 2'd2;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_BLOCK  = 3'd2;
    localparam logic [2:0] PH_COMPL  = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_CHK1   = 3'd5;
    localparam logic [2:0] PH_CHK2   = 3'd6;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic       kind;
        logic [7:0] link_byte;
        logic [7:0] block_number;
        logic       good;
        logic       pkt_end;
        logic [1:0] status;
    } t_result;

    // CRC-16/XMODEM, one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/xmodem_receiver.sv =====
// Timing: a word is first captured in the input register; when it advances, any result it
// makes is registered in the result register, o_out_valid rises, and it waits to be taken.
// Throughput: one word per cycle while results are taken; the input register and the result register let the
// next word come in while a result waits to be taken.
// The byte work (CRC-16 step, sum, phase decode) is one pass of logic between the two.
// Reset (i_rst_n low, synchronous) empties both registers, returns to idle, clears the
// session state and loads crc_mode 0, retry_limit 10.
module xmodem_receiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_command,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_result_kind,
    output logic [7:0]                      o_link_byte,
    output logic [7:0]                      o_block_number,
    output logic                            o_packet_good,
    output logic                            o_packet_end,
    output logic [1:0]                      o_session_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [xmr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [xmr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                      r_crc_mode;
    logic [3:0]                r_retry_limit;

    logic                      r_in_valid;
    logic                      r_in_cmd;
    logic [7:0]                r_in_byte;

    logic                      r_out_valid;
    xmr_pkg::t_result          r_out;

    logic [2:0]                r_phase;
    logic [xmr_pkg::CNT_W-1:0] r_payload_count;
    logic [15:0]               r_crc;
    logic [7:0]                r_sum;
    logic [7:0]                r_block;
    logic                      r_compl_ok;
    logic [7:0]                r_check_high;
    logic [3:0]                r_reject_count;

    logic [2:0]                n_phase;
    logic [xmr_pkg::CNT_W-1:0] n_payload_count;
    logic [15:0]               n_crc;
    logic [7:0]                n_sum;
    logic [7:0]                n_block;
    logic                      n_compl_ok;
    logic [7:0]                n_check_high;
    logic [3:0]                n_reject_count;
    logic                      n_has_result;
    xmr_pkg::t_result          n_out;

    logic                      advance;
    logic                      chk_match;
    logic                      do_verdict;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_mode    <= 1'b0;
            r_retry_limit <= xmr_pkg::RETRY_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                xmr_pkg::CFG_CRC_MODE:    r_crc_mode    <= i_cfg_data[0];
                xmr_pkg::CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_payload_count = r_payload_count;
        n_crc           = r_crc;
        n_sum           = r_sum;
        n_block         = r_block;
        n_compl_ok      = r_compl_ok;
        n_check_high    = r_check_high;
        n_reject_count  = r_reject_count;
        n_has_result    = 1'b0;
        chk_match       = 1'b0;
        do_verdict      = 1'b0;
        n_out.kind         = xmr_pkg::KIND_TX;
        n_out.link_byte    = xmr_pkg::BYTE_NAK;
        n_out.block_number = r_block;
        n_out.good         = 1'b0;
        n_out.pkt_end      = 1'b0;
        n_out.status       = xmr_pkg::ST_RUNNING;

        if (r_in_cmd == xmr_pkg::CMD_START) begin
            n_phase         = xmr_pkg::PH_HEADER;
            n_payload_count = '0;
            n_crc           = '0;
            n_sum           = '0;
            n_block         = '0;
            n_compl_ok      = 1'b0;
            n_check_high    = '0;
            n_reject_count  = '0;
            n_has_result    = 1'b1;
            n_out.link_byte    = r_crc_mode ? xmr_pkg::BYTE_C : xmr_pkg::BYTE_NAK;
            n_out.block_number = '0;
        end else begin
            case (r_phase)
                xmr_pkg::PH_HEADER: begin
                    if (r_in_byte == xmr_pkg::BYTE_EOT) begin
                        n_phase         = xmr_pkg::PH_IDLE;
                        n_has_result    = 1'b1;
                        n_out.link_byte = xmr_pkg::BYTE_ACK;
                        n_out.status    = xmr_pkg::ST_DONE;
                    end else begin
                        n_phase = xmr_pkg::PH_BLOCK;
                    end
                end
                xmr_pkg::PH_BLOCK: begin
                    n_block = r_in_byte;
                    n_phase = xmr_pkg::PH_COMPL;
                end
                xmr_pkg::PH_COMPL: begin
                    n_compl_ok      = (r_in_byte == ~r_block);
                    n_payload_count = '0;
                    n_crc           = '0;
                    n_sum           = '0;
                    n_phase         = xmr_pkg::PH_DATA;
                end
                xmr_pkg::PH_DATA: begin
                    n_crc           = xmr_pkg::crc_byte(r_crc, r_in_byte);
                    n_sum           = r_sum + r_in_byte;
                    n_payload_count = r_payload_count + 1'b1;
                    if (n_payload_count >= xmr_pkg::CNT_W'(xmr_pkg::PAYLOAD_BYTES)) begin
                        n_phase = xmr_pkg::PH_CHK1;
                    end
                    n_has_result    = 1'b1;
                    n_out.kind      = xmr_pkg::KIND_DATA;
                    n_out.link_byte = r_in_byte;
                end
                xmr_pkg::PH_CHK1: begin
                    if (r_crc_mode) begin
                        n_check_high = r_in_byte;
                        n_phase      = xmr_pkg::PH_CHK2;
                    end else begin
                        do_verdict = 1'b1;
                        chk_match  = (r_sum == r_in_byte);
                    end
                end
                xmr_pkg::PH_CHK2: begin
                    do_verdict = 1'b1;
                    chk_match  = (r_crc == {r_check_high, r_in_byte});
                end
                default: ;
            endcase

            if (do_verdict) begin
                n_has_result  = 1'b1;
                n_out.pkt_end = 1'b1;
                if (chk_match && r_compl_ok) begin
                    n_phase         = xmr_pkg::PH_HEADER;
                    n_out.link_byte = xmr_pkg::BYTE_ACK;
                    n_out.good      = 1'b1;
                end else if (r_reject_count >= r_retry_limit) begin
                    n_phase      = xmr_pkg::PH_IDLE;
                    n_out.status = xmr_pkg::ST_FAILED;
                end else begin
                    n_reject_count = r_reject_count + 1'b1;
                    n_phase        = xmr_pkg::PH_HEADER;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_phase         <= xmr_pkg::PH_IDLE;
            r_payload_count <= '0;
            r_crc           <= '0;
            r_sum           <= '0;
            r_block         <= '0;
            r_compl_ok      <= 1'b0;
            r_check_high    <= '0;
            r_reject_count  <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid     <= n_has_result;
                r_phase         <= n_phase;
                r_payload_count <= n_payload_count;
                r_crc           <= n_crc;
                r_sum           <= n_sum;
                r_block         <= n_block;
                r_compl_ok      <= n_compl_ok;
                r_check_high    <= n_check_high;
                r_reject_count  <= n_reject_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_cmd  <= i_command;
            r_in_byte <= i_rx_byte;
        end
        if (advance && n_has_result) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_out.kind;
    assign o_link_byte      = r_out.link_byte;
    assign o_block_number   = r_out.block_number;
    assign o_packet_good    = r_out.good;
    assign o_packet_end     = r_out.pkt_end;
    assign o_session_status = r_out.status;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_out_valid)
        else $error("input stalled without a pending word");

    a_good_is_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_good |->
            o_packet_end && o_link_byte == xmr_pkg::BYTE_ACK
            && o_result_kind == xmr_pkg::KIND_TX)
        else $error("good flag without an ACK verdict");

    a_start_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_cmd == xmr_pkg::CMD_START |=>
            r_phase == xmr_pkg::PH_HEADER && r_reject_count == '0 && r_out_valid)
        else $error("start did not open a session");

    a_fail_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_has_result && n_out.status == xmr_pkg::ST_FAILED |=>
            r_phase == xmr_pkg::PH_IDLE)
        else $error("failed session not idle");

endmodule

// ===== verif/xmodem_receiver_test.sv =====
module xmodem_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAT_CYCLES        = 4;
    localparam int SINK_HOLD_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int PHASE_WORDS       = 100;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic                           i_command;
    logic [7:0]                     i_rx_byte;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic                           o_result_kind;
    logic [7:0]                     o_link_byte;
    logic [7:0]                     o_block_number;
    logic                           o_packet_good;
    logic                           o_packet_end;
    logic [1:0]                     o_session_status;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [xmr_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [xmr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    xmodem_receiver DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_kind    (o_result_kind),
        .o_link_byte      (o_link_byte),
        .o_block_number   (o_block_number),
        .o_packet_good    (o_packet_good),
        .o_packet_end     (o_packet_end),
        .o_session_status (o_session_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // receiver session state as the block should hold it
    logic                 mdl_crc_mode    = 1'b0;
    logic [3:0]           mdl_retry_limit = xmr_pkg::RETRY_LIMIT_RST;
    logic [2:0]           rx_phase        = xmr_pkg::PH_IDLE;
    int                   rx_count        = 0;
    logic [15:0]          rx_crc          = '0;
    logic [7:0]           rx_sum          = '0;
    logic [7:0]           rx_block        = '0;
    logic                 rx_compl_ok     = 1'b0;
    logic [7:0]           rx_check_hi     = '0;
    logic [3:0]           rx_rejects      = '0;

    xmr_pkg::t_result     pending_outputs[$];
    int                   counted_words = 0;
    int                   mismatches    = 0;
    int                   quiet_cycles  = 0;
    int                   src_gap_pct   = 20;
    int                   sink_gap_pct  = 20;
    logic                 sink_hold     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) c = c ^ xmr_pkg::CRC_POLY;
        end
        return c;
    endfunction

    function automatic void push_word(input logic kind, input logic [7:0] lb,
                                      input logic [7:0] blk, input logic good,
                                      input logic pend, input logic [1:0] st);
        xmr_pkg::t_result w;
        w.kind         = kind;
        w.link_byte    = lb;
        w.block_number = blk;
        w.good         = good;
        w.pkt_end      = pend;
        w.status       = st;
        pending_outputs.push_back(w);
    endfunction

    task automatic close_packet(input logic match);
        if (match && rx_compl_ok) begin
            rx_phase = xmr_pkg::PH_HEADER;
            push_word(xmr_pkg::KIND_TX, xmr_pkg::BYTE_ACK, rx_block, 1'b1, 1'b1,
                      xmr_pkg::ST_RUNNING);
        end else if (rx_rejects >= mdl_retry_limit) begin
            rx_phase = xmr_pkg::PH_IDLE;
            push_word(xmr_pkg::KIND_TX, xmr_pkg::BYTE_NAK, rx_block, 1'b0, 1'b1,
                      xmr_pkg::ST_FAILED);
        end else begin
            rx_rejects++;
            rx_phase = xmr_pkg::PH_HEADER;
            push_word(xmr_pkg::KIND_TX, xmr_pkg::BYTE_NAK, rx_block, 1'b0, 1'b1,
                      xmr_pkg::ST_RUNNING);
        end
    endtask

    // advance the session by one accepted word
    task automatic receive_word(input logic cmd, input logic [7:0] b);
        if (cmd == xmr_pkg::CMD_START) begin
            rx_rejects  = '0;
            rx_block    = '0;
            rx_compl_ok = 1'b0;
            rx_count    = 0;
            rx_crc      = '0;
            rx_sum      = '0;
            rx_check_hi = '0;
            rx_phase    = xmr_pkg::PH_HEADER;
            counted_words++;
            push_word(xmr_pkg::KIND_TX, mdl_crc_mode ? xmr_pkg::BYTE_C : xmr_pkg::BYTE_NAK,
                      8'h00, 1'b0, 1'b0, xmr_pkg::ST_RUNNING);
            return;
        end
        if (rx_phase != xmr_pkg::PH_IDLE) counted_words++;
        case (rx_phase)
            xmr_pkg::PH_HEADER: begin
                if (b == xmr_pkg::BYTE_EOT) begin
                    rx_phase = xmr_pkg::PH_IDLE;
                    push_word(xmr_pkg::KIND_TX, xmr_pkg::BYTE_ACK, rx_block, 1'b0, 1'b0,
                              xmr_pkg::ST_DONE);
                end else begin
                    rx_phase = xmr_pkg::PH_BLOCK;
                end
            end
            xmr_pkg::PH_BLOCK: begin
                rx_block = b;
                rx_phase = xmr_pkg::PH_COMPL;
            end
            xmr_pkg::PH_COMPL: begin
                rx_compl_ok = (b == ~rx_block);
                rx_count    = 0;
                rx_crc      = '0;
                rx_sum      = '0;
                rx_phase    = xmr_pkg::PH_DATA;
            end
            xmr_pkg::PH_DATA: begin
                rx_crc = crc16_update(rx_crc, b);
                rx_sum = rx_sum + b;
                rx_count++;
                if (rx_count >= xmr_pkg::PAYLOAD_BYTES) rx_phase = xmr_pkg::PH_CHK1;
                push_word(xmr_pkg::KIND_DATA, b, rx_block, 1'b0, 1'b0, xmr_pkg::ST_RUNNING);
            end
            xmr_pkg::PH_CHK1: begin
                if (mdl_crc_mode) begin
                    rx_check_hi = b;
                    rx_phase    = xmr_pkg::PH_CHK2;
                end else begin
                    close_packet(rx_sum == b);
                end
            end
            xmr_pkg::PH_CHK2: close_packet(rx_crc == {rx_check_hi, b});
            default: ;
        endcase
    endtask

    // valid stays high after acceptance; whoever does something else lowers it
    task automatic send_word(input logic cmd, input logic [7:0] b);
        int gap;
        gap = pick_gap(src_gap_pct);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        receive_word(cmd, b);
    endtask

    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (LAT_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [xmr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [xmr_pkg::CFG_DATA_W-1:0] val);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == xmr_pkg::CFG_CRC_MODE) mdl_crc_mode = val[0];
        else if (idx == xmr_pkg::CFG_RETRY_LIMIT) mdl_retry_limit = val;
    endtask

    task automatic send_packet(input logic [7:0] blk, input logic bad_compl,
                               input logic bad_check);
        logic [7:0]  data [xmr_pkg::PAYLOAD_BYTES];
        logic [15:0] crc;
        logic [7:0]  sum;
        logic [7:0]  hdr;
        int          fill;
        fill = $urandom_range(9);
        crc  = '0;
        sum  = '0;
        for (int i = 0; i < xmr_pkg::PAYLOAD_BYTES; i++) begin
            data[i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
            crc     = crc16_update(crc, data[i]);
            sum     = sum + data[i];
        end
        hdr = ($urandom_range(3) != 0) ? 8'h01 : 8'($urandom);
        if (hdr == xmr_pkg::BYTE_EOT) hdr = 8'h02;
        send_word(xmr_pkg::CMD_BYTE, hdr);
        send_word(xmr_pkg::CMD_BYTE, blk);
        send_word(xmr_pkg::CMD_BYTE,
                  bad_compl ? (~blk ^ (8'h01 << $urandom_range(7))) : ~blk);
        foreach (data[i]) send_word(xmr_pkg::CMD_BYTE, data[i]);
        if (bad_check) begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
            sum = sum ^ (8'h01 << $urandom_range(7));
        end
        if (mdl_crc_mode) begin
            send_word(xmr_pkg::CMD_BYTE, crc[15:8]);
            send_word(xmr_pkg::CMD_BYTE, crc[7:0]);
        end else begin
            send_word(xmr_pkg::CMD_BYTE, sum);
        end
    endtask

    task automatic test_idle_bytes();
        send_word(xmr_pkg::CMD_BYTE, 8'h00);
        send_word(xmr_pkg::CMD_BYTE, 8'hFF);
        send_word(xmr_pkg::CMD_BYTE, xmr_pkg::BYTE_EOT);
    endtask

    task automatic test_open_close();
        send_word(xmr_pkg::CMD_START, 8'hFF);
        send_word(xmr_pkg::CMD_BYTE, xmr_pkg::BYTE_EOT);
        send_word(xmr_pkg::CMD_BYTE, 8'h55);
        write_reg(xmr_pkg::CFG_CRC_MODE, 4'd1);
        send_word(xmr_pkg::CMD_START, 8'h00);
        send_word(xmr_pkg::CMD_BYTE, 8'hFF);
        send_word(xmr_pkg::CMD_BYTE, 8'h00);
        send_word(xmr_pkg::CMD_START, 8'h00);
        send_word(xmr_pkg::CMD_BYTE, 8'h01);
        send_word(xmr_pkg::CMD_BYTE, 8'hFF);
        send_word(xmr_pkg::CMD_BYTE, 8'h00);
        send_word(xmr_pkg::CMD_BYTE, 8'hAA);
        send_word(xmr_pkg::CMD_START, 8'h5A);
        send_word(xmr_pkg::CMD_BYTE, xmr_pkg::BYTE_EOT);
    endtask

    task automatic test_random_sessions();
        logic       modes  [7] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        logic [3:0] limits [7] = '{4'd10, 4'd0, 4'd15, 4'd3, 4'd0, 4'd15, 4'd2};
        logic [7:0] blk;
        int         stop_at;
        int         pick;
        int         fault;
        for (int p = 0; p < 7; p++) begin
            write_reg(xmr_pkg::CFG_CRC_MODE, {3'b000, modes[p]});
            write_reg(xmr_pkg::CFG_RETRY_LIMIT, limits[p]);
            src_gap_pct  = (p == 2) ? 0 : $urandom_range(40, 5);
            sink_gap_pct = (p == 2) ? 0 : $urandom_range(40, 5);
            stop_at = counted_words + PHASE_WORDS;
            blk = 8'($urandom);
            while (counted_words < stop_at) begin
                if (rx_phase == xmr_pkg::PH_IDLE) begin
                    if ($urandom_range(3) == 0) send_word(xmr_pkg::CMD_BYTE, 8'($urandom));
                    send_word(xmr_pkg::CMD_START, 8'($urandom));
                end
                pick = $urandom_range(99);
                if (pick < 4) begin
                    send_word(xmr_pkg::CMD_BYTE, xmr_pkg::BYTE_EOT);
                end else if (pick < 8) begin
                    // packet cut short, then a new session
                    send_word(xmr_pkg::CMD_BYTE, 8'h01);
                    send_word(xmr_pkg::CMD_BYTE, blk);
                    repeat ($urandom_range(20)) send_word(xmr_pkg::CMD_BYTE, 8'($urandom));
                    send_word(xmr_pkg::CMD_START, 8'($urandom));
                end else begin
                    fault = $urandom_range(9);
                    send_packet(blk, fault == 0 || fault == 2, fault == 1 || fault == 2);
                    if (fault >= 3) blk++;
                end
            end
        end
    endtask

    task automatic test_backpressure();
        write_reg(xmr_pkg::CFG_CRC_MODE, 4'd1);
        src_gap_pct  = 0;
        sink_gap_pct = 0;
        send_word(xmr_pkg::CMD_START, 8'h00);
        sink_hold = 1'b1;
        send_packet(8'h01, 1'b0, 1'b0);
        wait_quiet();
    endtask

    task automatic test_limit_lowered();
        write_reg(xmr_pkg::CFG_CRC_MODE, 4'd1);
        write_reg(xmr_pkg::CFG_RETRY_LIMIT, 4'd15);
        src_gap_pct  = 20;
        sink_gap_pct = 20;
        send_word(xmr_pkg::CMD_START, 8'hFF);
        send_packet(8'h01, 1'b1, 1'b0);
        send_packet(8'h01, 1'b0, 1'b1);
        // limit now below the reject count; check type switches mid-session
        write_reg(xmr_pkg::CFG_RETRY_LIMIT, 4'd1);
        write_reg(xmr_pkg::CFG_CRC_MODE, 4'd0);
        send_packet(8'h01, 1'b0, 1'b0);
        send_packet(8'h02, 1'b1, 1'b1);
        send_word(xmr_pkg::CMD_BYTE, 8'h01);
        send_word(xmr_pkg::CMD_START, 8'h00);
        send_word(xmr_pkg::CMD_BYTE, xmr_pkg::BYTE_EOT);
    endtask

    initial begin : result_sink
        int gap;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold) begin
                i_out_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                sink_hold = 1'b0;
                i_out_ready <= 1'b1;
            end else begin
                gap = pick_gap(sink_gap_pct);
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        xmr_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outputs.size() == 0) begin
                $error("unexpected word: kind %0d, link_byte %0h", o_result_kind, o_link_byte);
                mismatches++;
            end else begin
                want = pending_outputs.pop_front();
                check_field("result_kind", want.kind, o_result_kind);
                check_field("link_byte", want.link_byte, o_link_byte);
                check_field("block_number", want.block_number, o_block_number);
                check_field("packet_good", want.good, o_packet_good);
                check_field("packet_end", want.pkt_end, o_packet_end);
                check_field("session_status", want.status, o_session_status);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** xmodem_receiver: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_command   <= xmr_pkg::CMD_BYTE;
        i_rx_byte   <= 8'h00;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= xmr_pkg::CFG_CRC_MODE;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_bytes();
        test_open_close();
        test_random_sessions();
        test_backpressure();
        test_limit_lowered();
        wait_quiet();
        if (mismatches == 0) begin
            $display("** xmodem_receiver: PASSED **");
        end else begin
            $display("** xmodem_receiver: FAILED **");
        end
        $finish;
    end

endmodule
